### rtl/sti_pkg.sv
// Shared types and codes for the sorted table coefficient interpolator.
package sti_pkg;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_WRITE  = 3'd1;
   localparam logic [2:0] OP_CHECK  = 3'd2;
   localparam logic [2:0] OP_INTERP = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TOO_MANY  = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_EMPTY     = 3'd3;
   localparam logic [2:0] ST_DUP       = 3'd4;
   localparam logic [2:0] ST_BAD_INDEX = 3'd5;

   localparam int KEY_W     = 20;
   localparam int VAL_W     = 48;
   localparam int DIV_STEPS = 16;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [19:0]        key;
      logic [3:0]         coeff_count;
      logic [3:0]         coeff_index;
      logic signed [47:0] coeff_value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [4:0]         out_count;
      logic [3:0]         out_slot;
      logic signed [47:0] out_value;
      logic [19:0]        out_key;
      logic               last;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_SHIFT_INIT,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_INS_NEW,
      S_INS_ZERO,
      S_CHK_RD,
      S_CHK_CMP,
      S_INT_SETUP,
      S_DIV,
      S_INT_CNT,
      S_COEF_RD,
      S_COEF_MUL,
      S_COEF_OUT
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       idx_clr;
      logic       idx_inc;
      logic       idx_dec;
      logic       idx_load_total;
      logic       ent_rd;
      logic       ent_rd_prev;
      logic       cap_prev;
      logic       cap_cur;
      logic       ent_wr_shift;
      logic       ent_wr_new;
      logic       slot_clr;
      logic       slot_inc;
      logic       coef_wr_zero;
      logic       coef_wr_val;
      logic       commit_insert;
      logic       clear_table;
      logic       int_setup;
      logic       div_step;
      logic       coef_rd;
      logic       mul;
      logic       emit;
      logic       emit_blend;
      logic       emit_key;
      logic [2:0] emit_status;
   } cmd_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic       cnt_too_big;
      logic       table_full;
      logic       table_empty;
      logic       idx_bad;
      logic       at_total;
      logic       at_pos;
      logic       key_le;
      logic       dup_now;
      logic       blend_now;
      logic       div_last;
      logic       n_zero;
      logic       zero_last;
      logic       slot_last;
   } stat_type;

endpackage

### rtl/sorted_table_coeff_interpolator_core.sv
// Top level of the sorted table coefficient interpolator.
// Usage: drive req_data and raise start while busy is low; the command is
// taken at that edge and busy stays high until its last result beat.
// Results appear on rsp_data for one cycle each, flagged by rsp_strobe; the
// receiver must take every beat, there is no back pressure. last marks the
// final beat of a command.
// Command flow, step by step:
//   write, clear, rejected commands: one status beat straight from dispatch.
//   check: reads and compares the records of the entry memory in turn until a
//   duplicate key or the end of the table.
//   insert: a walk to the slot, a shift of the entry memory one entry at a time
//   (read, write), then zeroing of every coefficient slot of the new row.
//   interpolate: a walk to the bracket, a serial divide when blending, then a
//   read, multiply and sum for each output coefficient.
// One command at a time; the next may start the cycle after busy falls.
// Reset empties the table; coefficient and entry memories keep their
// contents, which are never read before being written.
module sorted_table_coeff_interpolator_core #(
   parameter int MAX_RECORDS = 32,
   parameter int MAX_COEFF   = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sti_pkg::req_type req_data,
   output logic             rsp_strobe,
   output sti_pkg::rsp_type rsp_data
);

   sti_pkg::cmd_type  cmd;
   sti_pkg::stat_type stat;

   sti_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   sti_dpath #(
      .MAX_RECORDS (MAX_RECORDS),
      .MAX_COEFF   (MAX_COEFF)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

### rtl/sti_ctrl.sv
// Sequencer for the sorted table interpolator: walks, shifts, divides and emits.
module sti_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sti_pkg::stat_type stat,
   output sti_pkg::cmd_type  cmd
);

   sti_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sti_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != sti_pkg::S_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sti_pkg::S_IDLE: begin
            if (start) state_in = sti_pkg::S_DISPATCH;
         end
         sti_pkg::S_DISPATCH: begin
            state_in = sti_pkg::S_IDLE;
            case (stat.opcode)
               sti_pkg::OP_INSERT: begin
                  if (!stat.cnt_too_big && !stat.table_full) state_in = sti_pkg::S_SRCH_RD;
               end
               sti_pkg::OP_CHECK: begin
                  if (!stat.table_empty) state_in = sti_pkg::S_CHK_RD;
               end
               sti_pkg::OP_INTERP: begin
                  if (!stat.table_empty) state_in = sti_pkg::S_SRCH_RD;
               end
               default: state_in = sti_pkg::S_IDLE;
            endcase
         end
         sti_pkg::S_SRCH_RD: begin
            if (stat.at_total) begin
               state_in = (stat.opcode == sti_pkg::OP_INSERT) ? sti_pkg::S_SHIFT_INIT
                                                              : sti_pkg::S_INT_SETUP;
            end else begin
               state_in = sti_pkg::S_SRCH_CMP;
            end
         end
         sti_pkg::S_SRCH_CMP: begin
            if (stat.key_le) begin
               state_in = (stat.opcode == sti_pkg::OP_INSERT) ? sti_pkg::S_SHIFT_INIT
                                                              : sti_pkg::S_INT_SETUP;
            end else begin
               state_in = sti_pkg::S_SRCH_RD;
            end
         end
         sti_pkg::S_SHIFT_INIT: state_in = sti_pkg::S_SHIFT_RD;
         sti_pkg::S_SHIFT_RD: begin
            state_in = stat.at_pos ? sti_pkg::S_INS_NEW : sti_pkg::S_SHIFT_WR;
         end
         sti_pkg::S_SHIFT_WR: state_in = sti_pkg::S_SHIFT_RD;
         sti_pkg::S_INS_NEW:  state_in = sti_pkg::S_INS_ZERO;
         sti_pkg::S_INS_ZERO: begin
            if (stat.zero_last) state_in = sti_pkg::S_IDLE;
         end
         sti_pkg::S_CHK_RD: begin
            state_in = stat.at_total ? sti_pkg::S_IDLE : sti_pkg::S_CHK_CMP;
         end
         sti_pkg::S_CHK_CMP: begin
            state_in = stat.dup_now ? sti_pkg::S_IDLE : sti_pkg::S_CHK_RD;
         end
         sti_pkg::S_INT_SETUP: begin
            state_in = stat.blend_now ? sti_pkg::S_DIV : sti_pkg::S_INT_CNT;
         end
         sti_pkg::S_DIV: begin
            if (stat.div_last) state_in = sti_pkg::S_INT_CNT;
         end
         sti_pkg::S_INT_CNT: begin
            state_in = stat.n_zero ? sti_pkg::S_IDLE : sti_pkg::S_COEF_RD;
         end
         sti_pkg::S_COEF_RD:  state_in = sti_pkg::S_COEF_MUL;
         sti_pkg::S_COEF_MUL: state_in = sti_pkg::S_COEF_OUT;
         sti_pkg::S_COEF_OUT: begin
            state_in = stat.slot_last ? sti_pkg::S_IDLE : sti_pkg::S_COEF_RD;
         end
         default: state_in = sti_pkg::S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      cmd.emit_status = sti_pkg::ST_OK;
      case (state_ff)
         sti_pkg::S_IDLE: begin
            cmd.load_req = start;
         end
         sti_pkg::S_DISPATCH: begin
            case (stat.opcode)
               sti_pkg::OP_INSERT: begin
                  if (stat.cnt_too_big) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = sti_pkg::ST_TOO_MANY;
                  end else if (stat.table_full) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = sti_pkg::ST_FULL;
                  end else begin
                     cmd.idx_clr = 1'b1;
                  end
               end
               sti_pkg::OP_WRITE: begin
                  cmd.emit = 1'b1;
                  if (stat.table_empty) begin
                     cmd.emit_status = sti_pkg::ST_EMPTY;
                  end else if (stat.idx_bad) begin
                     cmd.emit_status = sti_pkg::ST_BAD_INDEX;
                  end else begin
                     cmd.coef_wr_val = 1'b1;
                  end
               end
               sti_pkg::OP_CHECK, sti_pkg::OP_INTERP: begin
                  if (stat.table_empty) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = sti_pkg::ST_EMPTY;
                  end else begin
                     cmd.idx_clr = 1'b1;
                  end
               end
               sti_pkg::OP_CLEAR: begin
                  cmd.clear_table = 1'b1;
                  cmd.emit        = 1'b1;
               end
               default: cmd.emit = 1'b1;
            endcase
         end
         sti_pkg::S_SRCH_RD: begin
            cmd.ent_rd = !stat.at_total;
         end
         sti_pkg::S_SRCH_CMP: begin
            if (stat.key_le) begin
               cmd.cap_cur = 1'b1;
            end else begin
               cmd.cap_prev = 1'b1;
               cmd.idx_inc  = 1'b1;
            end
         end
         sti_pkg::S_SHIFT_INIT: cmd.idx_load_total = 1'b1;
         sti_pkg::S_SHIFT_RD: begin
            cmd.ent_rd      = !stat.at_pos;
            cmd.ent_rd_prev = 1'b1;
         end
         sti_pkg::S_SHIFT_WR: begin
            cmd.ent_wr_shift = 1'b1;
            cmd.idx_dec      = 1'b1;
         end
         sti_pkg::S_INS_NEW: begin
            cmd.ent_wr_new = 1'b1;
            cmd.slot_clr   = 1'b1;
         end
         sti_pkg::S_INS_ZERO: begin
            cmd.coef_wr_zero = 1'b1;
            cmd.slot_inc     = 1'b1;
            if (stat.zero_last) begin
               cmd.commit_insert = 1'b1;
               cmd.emit          = 1'b1;
            end
         end
         sti_pkg::S_CHK_RD: begin
            if (stat.at_total) begin
               cmd.emit = 1'b1;
            end else begin
               cmd.ent_rd = 1'b1;
            end
         end
         sti_pkg::S_CHK_CMP: begin
            if (stat.dup_now) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = sti_pkg::ST_DUP;
            end else begin
               cmd.cap_prev = 1'b1;
               cmd.idx_inc  = 1'b1;
            end
         end
         sti_pkg::S_INT_SETUP: cmd.int_setup = 1'b1;
         sti_pkg::S_DIV:       cmd.div_step  = 1'b1;
         sti_pkg::S_INT_CNT: begin
            if (stat.n_zero) begin
               cmd.emit     = 1'b1;
               cmd.emit_key = 1'b1;
            end else begin
               cmd.slot_clr = 1'b1;
            end
         end
         sti_pkg::S_COEF_RD:  cmd.coef_rd = 1'b1;
         sti_pkg::S_COEF_MUL: cmd.mul     = 1'b1;
         sti_pkg::S_COEF_OUT: begin
            cmd.emit_blend = 1'b1;
            cmd.slot_inc   = !stat.slot_last;
         end
         default: cmd.emit_status = sti_pkg::ST_OK;
      endcase
   end

endmodule

### rtl/sti_dpath.sv
// Datapath: record and coefficient memories, walk counters, divider and blend arithmetic.
module sti_dpath #(
   parameter int MAX_RECORDS = 32,
   parameter int MAX_COEFF   = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  sti_pkg::req_type req_data,
   input  sti_pkg::cmd_type cmd,
   output sti_pkg::stat_type stat,
   output logic             rsp_strobe,
   output sti_pkg::rsp_type rsp_data
);

   localparam int AW  = $clog2(MAX_RECORDS);
   localparam int TW  = $clog2(MAX_RECORDS + 1);
   localparam int EW  = 24 + AW;
   localparam int CD  = MAX_RECORDS * MAX_COEFF;
   localparam int CAW = (CD > 1) ? $clog2(CD) : 1;
   localparam int SLW = (MAX_COEFF > 1) ? $clog2(MAX_COEFF + 1) : 1;
   localparam logic [CAW-1:0] MC_A = CAW'(MAX_COEFF);
   localparam logic signed [49:0] SAT_HI = 50'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [49:0] SAT_LO = 50'sh3_8000_0000_0000;

   // entry word: key, count, physical coefficient row
   logic [EW-1:0]       ent_mem [MAX_RECORDS];
   logic signed [47:0]  coef_mem [CD];

   sti_pkg::req_type    req_ff;
   logic [TW-1:0]       total_ff, idx_ff, pos_ff;
   logic [AW-1:0]       recent_row_ff, lo_row_ff, hi_row_ff;
   logic [3:0]          recent_cnt_ff;
   logic                found_ff;
   logic [EW-1:0]       prev_ff, cur_ff, ent_rd_ff;
   logic [4:0]          n_ff;
   logic [15:0]         w_ff;
   logic [19:0]         rem_ff, den_ff;
   logic [3:0]          div_cnt_ff;
   logic [SLW-1:0]      slot_ff;
   logic signed [47:0]  c0_ff, c1_ff;
   logic signed [65:0]  prod0_ff, prod1_ff;
   logic                rsp_strobe_ff;
   sti_pkg::rsp_type    rsp_ff;

   logic [TW-1:0]       idx_m1;
   logic [AW-1:0]       ent_ra, ent_wa;
   logic [EW-1:0]       ent_wd;
   logic                ent_we;
   logic [CAW-1:0]      coef_wa, coef_ra0, coef_ra1;
   logic signed [47:0]  coef_wd;
   logic                coef_we;
   logic [19:0]         ent_key, prev_key, cur_key;
   logic [3:0]          lo_cnt, hi_cnt, n_max;
   logic [EW-1:0]       lo_e, hi_e;
   logic                blend;
   logic [20:0]         div_t;
   logic                div_ge;
   logic [16:0]         wc;
   logic signed [17:0]  wc_s;
   logic signed [16:0]  w_s;
   logic signed [65:0]  sh0, sh1;
   logic signed [49:0]  sum;
   logic signed [47:0]  blend_val;

   assign ent_key  = ent_rd_ff[EW-1 -: 20];
   assign prev_key = prev_ff[EW-1 -: 20];
   assign cur_key  = cur_ff[EW-1 -: 20];

   assign idx_m1 = idx_ff - TW'(1);
   assign ent_ra = cmd.ent_rd_prev ? idx_m1[AW-1:0] : idx_ff[AW-1:0];
   assign ent_wa = cmd.ent_wr_new ? pos_ff[AW-1:0] : idx_ff[AW-1:0];
   assign ent_wd = cmd.ent_wr_new ? {req_ff.key, req_ff.coeff_count, total_ff[AW-1:0]}
                                  : ent_rd_ff;
   assign ent_we = cmd.ent_wr_new | cmd.ent_wr_shift;

   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[ent_wa] <= ent_wd;
      if (cmd.ent_rd) ent_rd_ff <= ent_mem[ent_ra];
   end

   assign coef_wa = cmd.coef_wr_zero ? CAW'(total_ff[AW-1:0]) * MC_A + CAW'(slot_ff)
                                     : CAW'(recent_row_ff) * MC_A + CAW'(req_ff.coeff_index);
   assign coef_wd  = cmd.coef_wr_zero ? 48'sd0 : req_ff.coeff_value;
   assign coef_we  = cmd.coef_wr_zero | cmd.coef_wr_val;
   assign coef_ra0 = CAW'(lo_row_ff) * MC_A + CAW'(slot_ff);
   assign coef_ra1 = CAW'(hi_row_ff) * MC_A + CAW'(slot_ff);

   always_ff @(posedge clock) begin
      if (coef_we) coef_mem[coef_wa] <= coef_wd;
      if (cmd.coef_rd) begin
         c0_ff <= coef_mem[coef_ra0];
         c1_ff <= coef_mem[coef_ra1];
      end
   end

   // bracket selection: blend between prev and cur, otherwise copy one record
   assign blend = found_ff && (pos_ff != '0) && (req_ff.key != cur_key);
   assign lo_e  = (!found_ff || blend) ? prev_ff : cur_ff;
   assign hi_e  = found_ff ? cur_ff : prev_ff;
   assign lo_cnt = lo_e[AW+3 -: 4];
   assign hi_cnt = hi_e[AW+3 -: 4];
   assign n_max  = (hi_cnt > lo_cnt) ? hi_cnt : lo_cnt;

   // restoring divide, one quotient bit per step
   assign div_t  = {rem_ff, 1'b0};
   assign div_ge = div_t >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= '0;
         recent_row_ff <= '0;
         recent_cnt_ff <= '0;
         idx_ff        <= '0;
         slot_ff       <= '0;
         div_cnt_ff    <= '0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit | cmd.emit_blend;
         if (cmd.clear_table) begin
            total_ff      <= '0;
            recent_row_ff <= '0;
            recent_cnt_ff <= '0;
         end else if (cmd.commit_insert) begin
            total_ff      <= total_ff + TW'(1);
            recent_row_ff <= total_ff[AW-1:0];
            recent_cnt_ff <= req_ff.coeff_count;
         end
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_load_total) begin
            idx_ff <= total_ff;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + TW'(1);
         end else if (cmd.idx_dec) begin
            idx_ff <= idx_m1;
         end
         if (cmd.slot_clr) begin
            slot_ff <= '0;
         end else if (cmd.slot_inc) begin
            slot_ff <= slot_ff + SLW'(1);
         end
         if (cmd.load_req) begin
            found_ff <= 1'b0;
         end else if (cmd.cap_cur) begin
            found_ff <= 1'b1;
         end
         if (cmd.int_setup) begin
            div_cnt_ff <= '0;
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
         pos_ff <= total_ff;
      end else if (cmd.cap_cur) begin
         pos_ff <= idx_ff;
      end
      if (cmd.cap_cur) cur_ff <= ent_rd_ff;
      if (cmd.cap_prev) prev_ff <= ent_rd_ff;
      if (cmd.int_setup) begin
         lo_row_ff <= lo_e[AW-1:0];
         hi_row_ff <= hi_e[AW-1:0];
         n_ff      <= ({1'b0, n_max} > 5'(MAX_COEFF)) ? 5'(MAX_COEFF) : {1'b0, n_max};
         w_ff      <= '0;
         rem_ff    <= req_ff.key - prev_key;
         den_ff    <= cur_key - prev_key;
      end else if (cmd.div_step) begin
         rem_ff <= div_ge ? 20'(div_t - {1'b0, den_ff}) : div_t[19:0];
         w_ff   <= {w_ff[14:0], div_ge};
      end
      if (cmd.mul) begin
         prod0_ff <= wc_s * c0_ff;
         prod1_ff <= w_s * c1_ff;
      end
   end

   assign wc   = 17'h10000 - {1'b0, w_ff};
   assign wc_s = $signed({1'b0, wc});
   assign w_s  = $signed({1'b0, w_ff});

   // arithmetic shift is a floor divide by 65536
   assign sh0 = prod0_ff >>> 16;
   assign sh1 = prod1_ff >>> 16;
   assign sum = sh0[49:0] + sh1[49:0];
   assign blend_val = (sum > SAT_HI) ? SAT_HI[47:0] :
                      (sum < SAT_LO) ? SAT_LO[47:0] : sum[47:0];

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.status    <= cmd.emit_status;
         rsp_ff.out_count <= '0;
         rsp_ff.out_slot  <= '0;
         rsp_ff.out_value <= '0;
         rsp_ff.out_key   <= cmd.emit_key ? req_ff.key : '0;
         rsp_ff.last      <= 1'b1;
      end else if (cmd.emit_blend) begin
         rsp_ff.status    <= sti_pkg::ST_OK;
         rsp_ff.out_count <= n_ff;
         rsp_ff.out_slot  <= 4'(slot_ff);
         rsp_ff.out_value <= blend_val;
         rsp_ff.out_key   <= req_ff.key;
         rsp_ff.last      <= stat.slot_last;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   assign stat.opcode      = req_ff.opcode;
   assign stat.cnt_too_big = int'(req_ff.coeff_count) > MAX_COEFF;
   assign stat.table_full  = (total_ff == TW'(MAX_RECORDS));
   assign stat.table_empty = (total_ff == '0);
   assign stat.idx_bad     = (req_ff.coeff_index >= recent_cnt_ff);
   assign stat.at_total    = (idx_ff == total_ff);
   assign stat.at_pos      = (idx_ff == pos_ff);
   assign stat.key_le      = (req_ff.key <= ent_key);
   assign stat.dup_now     = (idx_ff != '0) && (ent_key == prev_key);
   assign stat.blend_now   = blend;
   assign stat.div_last    = (div_cnt_ff == 4'(sti_pkg::DIV_STEPS - 1));
   assign stat.n_zero      = (n_ff == '0);
   assign stat.zero_last   = (slot_ff == SLW'(MAX_COEFF - 1));
   assign stat.slot_last   = ((5'(slot_ff) + 5'd1) == n_ff);

endmodule

### verif/sti_checker.sv
// Checker for the sorted table interpolator: predicts result beats and compares them.
`timescale 1ns / 100ps
module sti_checker #(
   parameter int MAX_RECORDS = 32,
   parameter int MAX_COEFF   = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  sti_pkg::req_type req_data,
   input  logic             rsp_strobe,
   input  sti_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_beats,
   output int               beats_seen
);

   localparam longint VMAX = (64'sd1 <<< 47) - 1;
   localparam longint VMIN = -(64'sd1 <<< 47);

   logic [19:0]        keys [MAX_RECORDS];
   logic [4:0]         counts [MAX_RECORDS];
   logic signed [47:0] coeffs [MAX_RECORDS][MAX_COEFF];
   int                 total;
   int                 recent;
   sti_pkg::rsp_type   expected_beats [$];

   function automatic longint floor_shr16(longint x);
      return x >>> 16;
   endfunction

   function automatic sti_pkg::rsp_type status_beat(logic [2:0] st);
      sti_pkg::rsp_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   task automatic predict_command(sti_pkg::req_type rq);
      int               pos, lo, hi, n;
      logic [15:0]      w;
      logic             blend;
      longint           num, den, c0, c1, acc;
      sti_pkg::rsp_type r;
      logic [2:0]       st;
      case (rq.opcode)
         sti_pkg::OP_INSERT: begin
            if (rq.coeff_count > MAX_COEFF)
               expected_beats.push_back(status_beat(sti_pkg::ST_TOO_MANY));
            else if (total >= MAX_RECORDS)
               expected_beats.push_back(status_beat(sti_pkg::ST_FULL));
            else begin
               pos = total;
               for (int i = 0; i < total; i++)
                  if (rq.key <= keys[i]) begin
                     pos = i;
                     break;
                  end
               for (int i = total; i > pos; i--) begin
                  keys[i] = keys[i-1];
                  counts[i] = counts[i-1];
                  for (int s = 0; s < MAX_COEFF; s++) coeffs[i][s] = coeffs[i-1][s];
               end
               keys[pos] = rq.key;
               counts[pos] = {1'b0, rq.coeff_count};
               for (int s = 0; s < MAX_COEFF; s++) coeffs[pos][s] = '0;
               total++;
               recent = pos;
               expected_beats.push_back(status_beat(sti_pkg::ST_OK));
            end
         end
         sti_pkg::OP_WRITE: begin
            if (total == 0 || recent >= total)
               expected_beats.push_back(status_beat(sti_pkg::ST_EMPTY));
            else if (rq.coeff_index >= counts[recent] || rq.coeff_index >= MAX_COEFF)
               expected_beats.push_back(status_beat(sti_pkg::ST_BAD_INDEX));
            else begin
               coeffs[recent][rq.coeff_index] = rq.coeff_value;
               expected_beats.push_back(status_beat(sti_pkg::ST_OK));
            end
         end
         sti_pkg::OP_CHECK: begin
            st = (total == 0) ? sti_pkg::ST_EMPTY : sti_pkg::ST_OK;
            for (int i = 1; i < total; i++)
               if (keys[i] == keys[i-1]) begin
                  st = sti_pkg::ST_DUP;
                  break;
               end
            expected_beats.push_back(status_beat(st));
         end
         sti_pkg::OP_INTERP: begin
            if (total == 0) expected_beats.push_back(status_beat(sti_pkg::ST_EMPTY));
            else begin
               pos = total;
               blend = 1'b0;
               w = '0;
               for (int i = 0; i < total; i++)
                  if (rq.key <= keys[i]) begin
                     pos = i;
                     break;
                  end
               if (pos == total) begin
                  lo = total - 1;
                  hi = lo;
               end else if (pos == 0 || rq.key == keys[pos]) begin
                  lo = pos;
                  hi = pos;
               end else begin
                  lo = pos - 1;
                  hi = pos;
                  num = longint'(rq.key - keys[lo]) << 16;
                  den = longint'(keys[hi] - keys[lo]);
                  w = 16'(num / den);
                  blend = 1'b1;
               end
               n = (counts[hi] > counts[lo]) ? counts[hi] : counts[lo];
               if (n > MAX_COEFF) n = MAX_COEFF;
               if (n == 0) begin
                  r = status_beat(sti_pkg::ST_OK);
                  r.out_key = rq.key;
                  expected_beats.push_back(r);
               end
               for (int s = 0; s < n; s++) begin
                  c0 = coeffs[lo][s];
                  c1 = coeffs[hi][s];
                  if (blend) begin
                     acc = floor_shr16((65536 - longint'(w)) * c0)
                         + floor_shr16(longint'(w) * c1);
                     if (acc > VMAX) acc = VMAX;
                     if (acc < VMIN) acc = VMIN;
                  end else acc = c0;
                  r.status = sti_pkg::ST_OK;
                  r.out_count = 5'(n);
                  r.out_slot = 4'(s);
                  r.out_value = 48'(acc);
                  r.out_key = rq.key;
                  r.last = (s + 1 == n);
                  expected_beats.push_back(r);
               end
            end
         end
         default: begin
            if (rq.opcode == sti_pkg::OP_CLEAR) begin
               total = 0;
               recent = 0;
            end
            expected_beats.push_back(status_beat(sti_pkg::ST_OK));
         end
      endcase
   endtask

   task automatic compare_beat(sti_pkg::rsp_type got);
      sti_pkg::rsp_type exp;
      if (expected_beats.size() == 0) begin
         $error("result beat with nothing expected: %p", got);
         fail_count++;
         return;
      end
      exp = expected_beats.pop_front();
      if (got.status !== exp.status) begin
         $error("status exp %0d got %0d", exp.status, got.status); fail_count++;
      end
      if (got.out_count !== exp.out_count) begin
         $error("out_count exp %0d got %0d", exp.out_count, got.out_count); fail_count++;
      end
      if (got.out_slot !== exp.out_slot) begin
         $error("out_slot exp %0d got %0d", exp.out_slot, got.out_slot); fail_count++;
      end
      if (got.out_value !== exp.out_value) begin
         $error("out_value exp %0d got %0d", exp.out_value, got.out_value); fail_count++;
      end
      if (got.out_key !== exp.out_key) begin
         $error("out_key exp %0h got %0h", exp.out_key, got.out_key); fail_count++;
      end
      if (got.last !== exp.last) begin
         $error("last exp %0b got %0b", exp.last, got.last); fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         total = 0;
         recent = 0;
         expected_beats.delete();
         fail_count = 0;
         beats_seen <= 0;
      end else begin
         if (rsp_strobe) begin
            compare_beat(rsp_data);
            beats_seen <= beats_seen + 1;
         end
         if (start && !busy) predict_command(req_data);
      end
      pending_beats <= expected_beats.size();
   end
endmodule

### verif/tb.sv
// Testbench top for the sorted table interpolator: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module tb;

   localparam int MAX_RECORDS = 32;
   localparam int MAX_COEFF   = 10;
   localparam int STALL_LIMIT = 2000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   sti_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   sti_pkg::rsp_type rsp_data;
   int               fail_count, pending_beats, beats_seen;
   int               idle_pct = 0;
   int               stall_cycles = 0;
   int               sent = 0;
   logic    [19:0]   key_pool [8];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sorted_table_coeff_interpolator_core #(
      .MAX_RECORDS(MAX_RECORDS), .MAX_COEFF(MAX_COEFF)
   ) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   sti_checker #(.MAX_RECORDS(MAX_RECORDS), .MAX_COEFF(MAX_COEFF)) checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .fail_count(fail_count),
      .pending_beats(pending_beats), .beats_seen(beats_seen)
   );

   // Count cycles with no beat moving either way.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog expired");
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_beat(sti_pkg::req_type rq);
      while ($urandom_range(99) < idle_pct) @(posedge clock);
      req_data <= rq;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 1'b0;
      sent++;
      // hold off until the command is done so start never overlaps busy rising
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic sti_pkg::req_type mk(logic [2:0] op, logic [19:0] k,
                                           logic [3:0] cnt, logic [3:0] idx,
                                           logic [47:0] v);
      sti_pkg::req_type r;
      r.opcode = op;
      r.key = k;
      r.coeff_count = cnt;
      r.coeff_index = idx;
      r.coeff_value = v;
      return r;
   endfunction

   function automatic logic [47:0] rnd_value();
      case ($urandom_range(3))
         0: return 48'h7FFF_FFFF_FFFF;
         1: return 48'h8000_0000_0000;
         default: return {16'($urandom), 32'($urandom)};
      endcase
   endfunction

   function automatic sti_pkg::req_type rnd_noise();
      return mk(3'($urandom), 20'($urandom), 4'($urandom), 4'($urandom), rnd_value());
   endfunction

   // Insert a record, write a random subset of its slots, then query around it.
   task automatic record_sequence();
      logic [19:0] k;
      int          cnt;
      k = ($urandom_range(3) == 0) ? 20'($urandom) : key_pool[$urandom_range(7)];
      cnt = $urandom_range(MAX_COEFF);
      send_beat(mk(sti_pkg::OP_INSERT, k, 4'(cnt), 4'($urandom), rnd_value()));
      for (int s = 0; s < cnt; s++)
         if ($urandom_range(4) != 0)
            send_beat(mk(sti_pkg::OP_WRITE, 20'($urandom), 4'($urandom), 4'(s),
                         rnd_value()));
      send_beat(mk(sti_pkg::OP_INTERP, k + 20'($urandom_range(200)) - 20'd100,
                   4'($urandom), 4'($urandom), rnd_value()));
   endtask

   initial begin
      for (int i = 0; i < 8; i++) key_pool[i] = 20'($urandom);
      key_pool[0] = 20'h0;
      key_pool[1] = 20'hFFFFF;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, too many coefficients, extremes, duplicates, bad index, unknown opcodes, full
      send_beat(mk(sti_pkg::OP_INTERP, 20'h100, 0, 0, 0));
      send_beat(mk(sti_pkg::OP_WRITE, 0, 0, 0, 48'h1));
      send_beat(mk(sti_pkg::OP_CHECK, 0, 0, 0, 0));
      send_beat(mk(sti_pkg::OP_INSERT, 20'h100, 4'd11, 0, 0));
      send_beat(mk(sti_pkg::OP_INSERT, 20'h100, 4'd15, 0, 0));
      send_beat(mk(sti_pkg::OP_INSERT, 20'h0, 4'd10, 0, 0));
      send_beat(mk(sti_pkg::OP_WRITE, 0, 0, 4'd0, 48'h7FFF_FFFF_FFFF));
      send_beat(mk(sti_pkg::OP_WRITE, 0, 0, 4'd9, 48'h8000_0000_0000));
      send_beat(mk(sti_pkg::OP_WRITE, 0, 0, 4'd10, 48'h1));
      send_beat(mk(sti_pkg::OP_WRITE, 0, 0, 4'd15, 48'h1));
      send_beat(mk(sti_pkg::OP_INSERT, 20'hFFFFF, 4'd3, 0, 0));
      send_beat(mk(sti_pkg::OP_WRITE, 0, 0, 4'd0, 48'h8000_0000_0000));
      send_beat(mk(sti_pkg::OP_WRITE, 0, 0, 4'd1, 48'h7FFF_FFFF_FFFF));
      send_beat(mk(sti_pkg::OP_INTERP, 20'h0, 0, 0, 0));
      send_beat(mk(sti_pkg::OP_INTERP, 20'h7FFFF, 0, 0, 0));
      send_beat(mk(sti_pkg::OP_INTERP, 20'hFFFFF, 0, 0, 0));
      send_beat(mk(sti_pkg::OP_INSERT, 20'hFFFFF, 4'd0, 0, 0));
      send_beat(mk(sti_pkg::OP_CHECK, 0, 0, 0, 0));
      send_beat(mk(sti_pkg::OP_INTERP, 20'hFFFFF, 0, 0, 0));
      send_beat(mk(3'd5, 20'hFFFFF, 4'hF, 4'hF, 48'hFFFF_FFFF_FFFF));
      send_beat(mk(3'd7, 0, 0, 0, 0));
      send_beat(mk(sti_pkg::OP_CLEAR, 0, 0, 0, 0));
      send_beat(mk(sti_pkg::OP_INSERT, 20'h500, 4'd0, 0, 0));
      send_beat(mk(sti_pkg::OP_INTERP, 20'h500, 0, 0, 0));
      for (int i = 0; i < MAX_RECORDS; i++)
         send_beat(mk(sti_pkg::OP_INSERT, 20'($urandom), 4'($urandom_range(2)), 0, 0));
      send_beat(mk(sti_pkg::OP_CHECK, 0, 0, 0, 0));
      send_beat(mk(sti_pkg::OP_INTERP, 20'($urandom), 0, 0, 0));
      send_beat(mk(sti_pkg::OP_CLEAR, 0, 0, 0, 0));

      // random: three idle profiles, mostly well formed sequences
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 34 : (phase == 1) ? 82 : 0;
         while (sent < 60 + 84 * (phase + 1)) begin
            case ($urandom_range(9))
               0: send_beat(rnd_noise());
               1: send_beat(mk(sti_pkg::OP_CHECK, 20'($urandom), 0, 0, 0));
               2: if ($urandom_range(5) == 0) send_beat(mk(sti_pkg::OP_CLEAR, 0, 0, 0, 0));
                  else send_beat(mk(sti_pkg::OP_INTERP, 20'($urandom), 0, 0, 0));
               default: record_sequence();
            endcase
         end
      end

      while (pending_beats != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("sent %0d commands, checked %0d result beats across three idle profiles",
               sent, beats_seen);
      if (fail_count == 0 && pending_beats == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

### files.f
rtl/sti_pkg.sv
rtl/sti_ctrl.sv
rtl/sti_dpath.sv
rtl/sorted_table_coeff_interpolator_core.sv
verif/sti_checker.sv
verif/tb.sv
